// File: hdl/softmax_top1_confidence_assert.svh
// Assertion macros for the top-1 softmax confidence block.
`ifndef SOFTMAX_TOP1_CONFIDENCE_ASSERT_SVH
`define SOFTMAX_TOP1_CONFIDENCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define SMX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smx assertion failed");

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define SMX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smx assertion failed");

`endif

// File: hdl/smx_pkg.sv
// Shared types, constants and arithmetic helpers for the softmax top-1 block.
package smx_pkg;

  localparam int CLASS_W = 10;
  localparam int CONF_W  = 16;
  localparam int D_W     = 12;   // clamped exponent argument, Q8.8
  localparam int X_W     = 13;   // d * log2(e) in Q8.8
  localparam int E_W     = 17;   // exp result, 1.0 = 65536
  localparam int SUM_W   = 32;

  localparam logic [D_W-1:0]   D_MAX     = 12'd4095;  // exp is zero well below this
  localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
  localparam logic [SUM_W-1:0] ONE_Q16   = 32'd65536;

  // 2^32 / sum: sum >= 2^16, so quotient bits above 16 are zero
  localparam int               DIV_STEPS = 17;
  localparam logic [SUM_W-1:0] DIV_INIT  = 32'h0000_8000;

  localparam logic [1:0] KIND_FIRST = 2'd0;  // first item of a row
  localparam logic [1:0] KIND_RAISE = 2'd1;  // new strict maximum
  localparam logic [1:0] KIND_ADD   = 2'd2;  // at or below the maximum

  typedef struct packed {
    logic [1:0]         kind;
    logic [D_W-1:0]     d;
    logic               last;
    logic [CLASS_W-1:0] pos;
  } smx_entry_t;

  function automatic logic [E_W-1:0] pow2_tab(input logic [4:0] idx);
    logic [E_W-1:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60096;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = '0;
    endcase
    return v;
  endfunction

  // 2^(-x/256) scaled by 65536, linear interpolation between 17 table points
  function automatic logic [E_W-1:0] exp_frac(input logic [X_W-1:0] x);
    logic [4:0]     n;
    logic [4:0]     hi;
    logic [3:0]     lo;
    logic [E_W-1:0] t0;
    logic [E_W-1:0] t1;
    logic [E_W-1:0] dt;
    logic [20:0]    p;
    logic [E_W-1:0] m;
    n  = x[12:8];
    hi = {1'b0, x[7:4]};
    lo = x[3:0];
    t0 = pow2_tab(hi);
    t1 = pow2_tab(hi + 5'd1);
    dt = t0 - t1;
    p  = 21'(dt) * 21'(lo);
    m  = t0 - E_W'(p >> 4);
    if (n > 5'd16) begin
      return '0;
    end
    return m >> n;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

// File: hdl/smx_if.sv
// Valid/ready channel interfaces for activations in and top-1 results out.
interface smx_in_if #(
  parameter int ACT_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [ACT_WIDTH-1:0] activation;
  logic                        row_end;

  modport source (output valid, output activation, output row_end, input ready);
  modport sink   (input valid, input activation, input row_end, output ready);
endinterface

interface smx_out_if;
  logic                                valid;
  logic                                ready;
  logic [smx_pkg::CLASS_W-1:0]         best_class;
  logic [smx_pkg::CONF_W-1:0]          confidence;

  modport source (output valid, output best_class, output confidence, input ready);
  modport sink   (input valid, input best_class, input confidence, output ready);
endinterface

// File: hdl/smx_front.sv
// Front end: tracks the row maximum and positions, classifies each activation.
module smx_front #(
  parameter int MAX_CLASSES = 1024,
  parameter int ACT_WIDTH   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [ACT_WIDTH-1:0] in_activation,
  input  logic                        in_row_end,
  output logic                        push_valid,
  input  logic                        push_ready,
  output smx_pkg::smx_entry_t         push_entry
);

  localparam int PW = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
  localparam int XW = (ACT_WIDTH + 1 > smx_pkg::D_W) ? ACT_WIDTH + 1 : smx_pkg::D_W;

  logic                        started_r, started_nxt;
  logic signed [ACT_WIDTH-1:0] max_r, max_nxt;
  logic [PW-1:0]               best_r, best_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;

  logic                        accept;
  logic                        raise;
  logic signed [ACT_WIDTH:0]   diff;
  logic [XW-1:0]               diff_x;
  logic [smx_pkg::D_W-1:0]     d_clamp;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign raise      = started_r && (in_activation > max_r);

  always_comb begin
    if (raise) begin
      diff = (ACT_WIDTH+1)'(in_activation) - (ACT_WIDTH+1)'(max_r);
    end else begin
      diff = (ACT_WIDTH+1)'(max_r) - (ACT_WIDTH+1)'(in_activation);
    end
    diff_x = XW'(unsigned'(diff));
    if (!started_r) begin
      d_clamp = '0;
    end else if (diff_x > XW'(smx_pkg::D_MAX)) begin
      d_clamp = smx_pkg::D_MAX;
    end else begin
      d_clamp = diff_x[smx_pkg::D_W-1:0];
    end
  end

  always_comb begin
    best_nxt    = (!started_r || raise) ? pos_r : best_r;
    max_nxt     = (!started_r || raise) ? in_activation : max_r;
    started_nxt = started_r;
    pos_nxt     = pos_r;
    if (accept) begin
      if (in_row_end) begin
        started_nxt = 1'b0;
        pos_nxt     = '0;
      end else begin
        started_nxt = 1'b1;
        pos_nxt     = (pos_r == PW'(MAX_CLASSES - 1)) ? '0 : pos_r + PW'(1);
      end
    end
  end

  always_comb begin
    if (!started_r) begin
      push_entry.kind = smx_pkg::KIND_FIRST;
    end else if (raise) begin
      push_entry.kind = smx_pkg::KIND_RAISE;
    end else begin
      push_entry.kind = smx_pkg::KIND_ADD;
    end
    push_entry.d    = d_clamp;
    push_entry.last = in_row_end;
    push_entry.pos  = smx_pkg::CLASS_W'(best_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      pos_r     <= '0;
      max_r     <= '0;
      best_r    <= '0;
    end else begin
      started_r <= started_nxt;
      pos_r     <= pos_nxt;
      if (accept) begin
        max_r  <= max_nxt;
        best_r <= best_nxt;
      end
    end
  end

endmodule

// File: hdl/smx_fifo.sv
// Two-entry queue between the front end and the arithmetic back end.
module smx_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  smx_pkg::smx_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output smx_pkg::smx_entry_t pop_entry
);

  localparam int DEPTH = 2;
  localparam int AW    = 1;

  smx_pkg::smx_entry_t mem_r [DEPTH];
  logic [AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [AW:0]         cnt_r;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != (AW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: hdl/smx_back.sv
// Back end: exp evaluation, online sum update, reciprocal divide, result register.
module smx_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  smx_pkg::smx_entry_t           pop_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [smx_pkg::CLASS_W-1:0]   out_best_class,
  output logic [smx_pkg::CONF_W-1:0]    out_confidence
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EXP  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_RESC = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int CW = $clog2(smx_pkg::DIV_STEPS + 1);

  logic [2:0]                    state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  smx_pkg::smx_entry_t           ent_r, ent_nxt;
  logic [smx_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [smx_pkg::X_W-1:0]       x_r, x_nxt;
  logic [smx_pkg::E_W-1:0]       e_r, e_nxt;
  logic [smx_pkg::SUM_W-1:0]     prod_r, prod_nxt;
  logic [smx_pkg::SUM_W-1:0]     rem_r, rem_nxt;
  logic [smx_pkg::E_W-1:0]       quo_r, quo_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [smx_pkg::CLASS_W-1:0]   cls_r, cls_nxt;
  logic [smx_pkg::CONF_W-1:0]    conf_r, conf_nxt;

  logic                          fin;
  logic                          fin_last;
  logic [28:0]                   xmul;
  logic [48:0]                   smul;
  logic [smx_pkg::SUM_W:0]       trial;

  assign pop_ready      = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_best_class = cls_r;
  assign out_confidence = conf_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ent_nxt       = ent_r;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    e_nxt         = e_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    cls_nxt       = cls_r;
    conf_nxt      = conf_r;
    fin           = 1'b0;
    fin_last      = ent_r.last;
    xmul          = 29'(ent_r.d) * 29'(smx_pkg::LOG2E_Q16);
    smul          = 49'(sum_r) * 49'(e_r);
    trial         = {rem_r, 1'b0};

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          ent_nxt = pop_entry;
          if (pop_entry.kind == smx_pkg::KIND_FIRST) begin
            sum_nxt  = smx_pkg::ONE_Q16;
            fin      = 1'b1;
            fin_last = pop_entry.last;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        x_nxt     = xmul[28:16];
        state_nxt = S_EXP;
      end
      S_EXP: begin
        e_nxt     = smx_pkg::exp_frac(x_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (ent_r.kind == smx_pkg::KIND_RAISE) begin
          // old terms rescaled by exp(old_max - new_max)
          prod_nxt  = smul[47:16];
          state_nxt = S_RESC;
        end else begin
          sum_nxt = smx_pkg::sat_add(sum_r, smx_pkg::SUM_W'(e_r));
          fin     = 1'b1;
        end
      end
      S_RESC: begin
        sum_nxt = smx_pkg::sat_add(prod_r, smx_pkg::ONE_Q16);
        fin     = 1'b1;
      end
      S_DIV: begin
        // restoring step; remainder stays below sum so it fits 32 bits
        if (trial >= {1'b0, sum_r}) begin
          rem_nxt = smx_pkg::SUM_W'(trial - {1'b0, sum_r});
          quo_nxt = {quo_r[smx_pkg::E_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[smx_pkg::SUM_W-1:0];
          quo_nxt = {quo_r[smx_pkg::E_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          cls_nxt       = ent_r.pos;
          conf_nxt      = quo_r[smx_pkg::E_W-1] ? '1 : quo_r[smx_pkg::CONF_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (fin_last) begin
        rem_nxt   = smx_pkg::DIV_INIT;
        quo_nxt   = '0;
        cnt_nxt   = CW'(smx_pkg::DIV_STEPS);
        state_nxt = S_DIV;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    sum_r  <= sum_nxt;
    x_r    <= x_nxt;
    e_r    <= e_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    cls_r  <= cls_nxt;
    conf_r <= conf_nxt;
  end

endmodule

// File: hdl/softmax_top1_confidence.sv
// Top-1 softmax confidence: streams a row of Q8.8 activations, returns argmax and 1/sum.
//
// in_ch carries one signed activation per transaction plus row_end on the last of a
// row; out_ch carries one transaction per row: best_class (first strict maximum,
// position modulo MAX_CLASSES, low 10 bits) and confidence in unsigned Q0.16.
// The front end takes a transaction in any cycle the two-entry queue has room,
// so short bursts enter back to back. The back end takes one item at a time: the
// first item of a row is taken directly, an item at or below the running
// maximum passes through exp argument multiply, table interpolation and accumulate,
// and a new maximum adds the 32x17 rescale multiply.
// After the last item of a row the back end runs a restoring divide for
// 2^32/sum and then loads the output register, where out_ch.valid rises.
// While out_ch is stalled the result holds; the back end waits with the next
// result and the queue fills, after which in_ch.ready drops.
// Synchronous reset clears the row state, the queue and the output valid flag.
`include "softmax_top1_confidence_assert.svh"

module softmax_top1_confidence #(
  parameter int MAX_CLASSES = 1024,
  parameter int ACT_WIDTH   = 16
) (
  input logic       clk,
  input logic       rst_n,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch
);

  logic                push_valid, push_ready;
  smx_pkg::smx_entry_t push_entry;
  logic                pop_valid, pop_ready;
  smx_pkg::smx_entry_t pop_entry;

  smx_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .ACT_WIDTH   (ACT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_activation (in_ch.activation),
    .in_row_end    (in_ch.row_end),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  smx_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  smx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_best_class (out_ch.best_class),
    .out_confidence (out_ch.confidence)
  );

  // an empty queue always has room for the front end
  `SMX_ASSERT_NOW(a_empty_queue_accepts, !pop_valid, push_ready)
  // sum never exceeds 2^32-1, so the reciprocal is never zero
  `SMX_ASSERT_NOW(a_conf_nonzero, out_ch.valid, out_ch.confidence != '0)
  // the entry pushed after a row's last one opens a new row
  `SMX_ASSERT_NEXT(a_row_start_after_end,
                   push_valid && push_ready && push_entry.last,
                   !(push_valid && push_ready) ||
                   push_entry.kind == smx_pkg::KIND_FIRST)

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the top-1 softmax confidence block.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned LOG2E = 94548;
  localparam logic [31:0] ONE_Q16 = 32'd65536;

  typedef struct packed {
    logic [smx_pkg::CLASS_W-1:0] best_class;
    logic [smx_pkg::CONF_W-1:0]  confidence;
  } top1_t;

  typedef struct {
    int act;
    bit last;
    bit typed;
    int cls;
    int conf;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  smx_in_if #(.ACT_WIDTH(16)) in_ch();
  smx_out_if out_ch();

  softmax_top1_confidence #(
    .MAX_CLASSES(1024),
    .ACT_WIDTH  (16)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // 2^(-k/16) in Q16, interpolation knots for the exp approximation
  int unsigned knots [0:16] = '{
    65536, 62757, 60096, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  // row tracking state of the predictor
  bit                 row_open;
  logic signed [15:0] peak_act;
  logic [9:0]         peak_pos;
  logic [9:0]         next_pos;
  logic [31:0]        exp_sum;

  top1_t pending[$];
  int    mismatches   = 0;
  int    rows_checked = 0;
  int    items_sent   = 0;
  int    snd_idle_pct = 0;
  int    rcv_stall_pct = 0;
  int    hold_reqs    = 0;

  stim_row_t directed [0:23] = '{
    '{0,       1, 1, 0, 65535},   // single-item row
    '{-32768,  0, 0, 0, 0},
    '{32767,   1, 1, 1, 65535},   // rise across the full range: old sum decays to zero
    '{32767,   0, 0, 0, 0},
    '{-32768,  1, 1, 0, 65535},
    '{100,     0, 0, 0, 0},
    '{100,     1, 1, 0, 32768},   // tie keeps the first position
    '{-32768,  0, 0, 0, 0},
    '{-32768,  0, 0, 0, 0},
    '{-32768,  1, 1, 0, 21845},
    '{0,       0, 0, 0, 0},
    '{256,     0, 0, 0, 0},
    '{-256,    0, 0, 0, 0},
    '{512,     0, 0, 0, 0},
    '{511,     1, 0, 0, 0},
    '{-5,      0, 0, 0, 0},
    '{3,       0, 0, 0, 0},
    '{3,       0, 0, 0, 0},
    '{-200,    1, 0, 0, 0},
    '{0,       0, 0, 0, 0},
    '{-2900,   0, 0, 0, 0},       // shift of 16, truncates to zero
    '{-3100,   0, 0, 0, 0},       // past the cutoff
    '{-1000,   0, 0, 0, 0},
    '{-100,    1, 0, 0, 0}
  };

  function automatic logic [16:0] decay_q16(input int unsigned gap);
    longint unsigned x;
    longint unsigned n;
    int unsigned     hi;
    int unsigned     lo;
    int unsigned     m;
    x  = (64'(gap) * LOG2E) >> 16;
    n  = x >> 8;
    hi = int'((x & 255) >> 4);
    lo = int'(x & 15);
    if (n > 16) begin
      return '0;
    end
    m = knots[hi] - (((knots[hi] - knots[hi+1]) * lo) >> 4);
    return 17'(m >> n);
  endfunction

  function automatic logic [31:0] sum_sat(input logic [31:0] a, input logic [31:0] b);
    longint unsigned s;
    s = 64'(a) + 64'(b);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic advance_row(input logic signed [15:0] act, input bit last,
                             output bit emitted, output top1_t res);
    longint unsigned scaled;
    longint unsigned quot;
    int              gap;
    emitted = 1'b0;
    res     = '0;
    if (!row_open) begin
      peak_act = act;
      peak_pos = next_pos;
      exp_sum  = ONE_Q16;
      row_open = 1'b1;
    end else if (act > peak_act) begin
      // new maximum: rescale what was summed against the old one
      gap      = int'(act) - int'(peak_act);
      scaled   = (64'(exp_sum) * 64'(decay_q16(gap))) >> 16;
      exp_sum  = sum_sat(32'(scaled), ONE_Q16);
      peak_act = act;
      peak_pos = next_pos;
    end else begin
      gap     = int'(peak_act) - int'(act);
      exp_sum = sum_sat(exp_sum, 32'(decay_q16(gap)));
    end
    next_pos = next_pos + 10'd1;
    if (last) begin
      quot = 64'h1_0000_0000 / 64'(exp_sum);
      if (quot > 65535) begin
        quot = 65535;
      end
      res.best_class = peak_pos;
      res.confidence = 16'(quot);
      emitted  = 1'b1;
      row_open = 1'b0;
      peak_act = '0;
      peak_pos = '0;
      next_pos = '0;
      exp_sum  = '0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic push_item(input logic signed [15:0] act, input bit last,
                           input bit typed, input top1_t typed_res);
    bit    emitted;
    top1_t res;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.activation <= act;
    in_ch.row_end    <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_row(act, last, emitted, res);
    if (emitted) begin
      pending.insert(pending.size(), typed ? typed_res : res);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_row(input int len);
    int                 v;
    logic signed [15:0] base;
    logic signed [15:0] prev;
    top1_t              none;
    none = '0;
    base = 16'($urandom);
    prev = base;
    for (int i = 0; i < len; i++) begin
      // mostly near a row base so the exp terms stay nonzero
      case ($urandom_range(4))
        0:       v = int'(base) + int'($urandom_range(1200)) - 600;
        1:       v = int'($signed(16'($urandom)));
        2:       v = int'(prev);
        3:       v = int'(base) - int'($urandom_range(3300));
        default: v = int'(base) + int'($urandom_range(200));
      endcase
      if (v > 32767) begin
        v = 32767;
      end
      if (v < -32768) begin
        v = -32768;
      end
      prev = 16'(v);
      push_item(prev, i == len - 1, 1'b0, none);
    end
  endtask

  // result side: random stalls, plus a long hold on request
  initial begin
    int hold_left;
    int hold_seen;
    out_ch.ready = 1'b0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    top1_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: best_class %0d confidence %0d",
                   out_ch.best_class, out_ch.confidence);
        end
      end else begin
        want = pending.pop_front();
        rows_checked++;
        if (out_ch.best_class !== want.best_class ||
            out_ch.confidence !== want.confidence) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on row %0d: best_class exp %0d got %0d, confidence exp %0d got %0d",
                     rows_checked, want.best_class, out_ch.best_class,
                     want.confidence, out_ch.confidence);
          end
        end
      end
    end
  end

  initial begin
    int                 phase_items;
    int                 len;
    top1_t              none;
    int                 idle_mix  [0:3];
    int                 stall_mix [0:3];
    none      = '0;
    idle_mix  = '{0, 68, 0, 22};
    stall_mix = '{0, 0, 68, 22};
    row_open = 1'b0;
    peak_act = '0;
    peak_pos = '0;
    next_pos = '0;
    exp_sum  = '0;
    in_ch.valid      = 1'b0;
    in_ch.activation = '0;
    in_ch.row_end    = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      push_item(16'(directed[i].act), directed[i].last, directed[i].typed,
                '{best_class: 10'(directed[i].cls), confidence: 16'(directed[i].conf)});
    end

    // output held off while single-item rows keep coming: queue fills, input stalls
    hold_reqs++;
    repeat (24) send_random_row(1);
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct  = idle_mix[ph];
      rcv_stall_pct = stall_mix[ph];
      phase_items = 0;
      while (phase_items < 85) begin
        len = ($urandom_range(99) < 80) ? int'($urandom_range(1, 12))
                                        : int'($urandom_range(13, 48));
        send_random_row(len);
        phase_items += len;
      end
      if (ph == 1) begin
        // sender pauses until every result is back
        in_ch.valid <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
        @(negedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    mismatches += pending.size();
    $display("covered %0d items over %0d rows: extremes, ties, exp cutoff, random rows",
             items_sent, rows_checked);
    $display("idle mixes none, sender 68%%, receiver 68%%, both 22%%, plus a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/smx_pkg.sv
hdl/smx_if.sv
hdl/smx_front.sv
hdl/smx_fifo.sv
hdl/smx_back.sv
hdl/softmax_top1_confidence.sv
dv/tb_top.sv
